// ===== sv/beq_pkg.sv =====
// Shared types, constants and arithmetic helpers for the biquad cascade equalizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package beq_pkg;

  // default configuration
  localparam int NUM_NODES_DEF  = 8;
  localparam int CUT_STAGES_DEF = 2;

  // field widths
  localparam int MASK_W    = 8;
  localparam int REQ_W     = 2;
  localparam int SAMPLE_W  = 24;
  localparam int STIDX_W   = 4;
  localparam int SEL_W     = 3;
  localparam int COEF_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_COEFS = 5;

  // datapath widths
  localparam int PROD_W = 64;   // coefficient times operand
  localparam int RND_W  = 54;   // product rounded to Q.40
  localparam int ACC_W  = 56;   // partial sums of z1/z2
  localparam int SUM_W  = 57;   // sums ahead of saturation
  localparam int Z_W    = 48;   // delay state
  localparam int Y_W    = 32;   // stage output, Q8.23

  // request codes
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_COEF   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // coefficient select codes
  localparam logic [SEL_W-1:0] COEF_B0 = 3'd0;
  localparam logic [SEL_W-1:0] COEF_B1 = 3'd1;
  localparam logic [SEL_W-1:0] COEF_B2 = 3'd2;
  localparam logic [SEL_W-1:0] COEF_A1 = 3'd3;
  localparam logic [SEL_W-1:0] COEF_A2 = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CUT  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } beq_state_t;

  // one phase per multiply of a stage
  typedef enum logic [2:0] {
    PH_B0,
    PH_B1,
    PH_A1,
    PH_B2,
    PH_A2
  } beq_phase_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_Y,
    DP_LOAD,
    DP_SUB,
    DP_Z1
  } beq_dp_op_t;

  typedef struct packed {
    beq_dp_op_t op;
    logic       mul_y;    // multiply by y instead of x
    logic       wr_z2;    // write z2 of the previous stage
    logic       x_adv;    // stage output becomes next stage input
    logic       load_x;   // take the new sample
    logic       clear_z;  // zero all delay state
  } beq_ctrl_t;

  // floor((p + 2^9) / 2^10)
  function automatic logic signed [RND_W-1:0] round10(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(512);
    return t[PROD_W-1:10];
  endfunction

  // saturate to the signed 48-bit range
  function automatic logic signed [Z_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-Z_W:0] upper;
    upper = v[SUM_W-1:Z_W-1];
    if ((&upper) || (~|upper)) begin
      return v[Z_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Z_W-1){1'b1}}};
    end
  endfunction

  // floor((a + 2^16) / 2^17), Q7.40 to Q8.23
  function automatic logic signed [Y_W-1:0] y_round(input logic signed [Z_W-1:0] a);
    logic signed [Z_W:0] t;
    t = $signed({a[Z_W-1], a}) + $signed((Z_W+1)'(65536));
    return t[Z_W:17];
  endfunction

endpackage

`default_nettype wire

// ===== sv/beq_if.sv =====
// Handshake channels of the equalizer: request items in, result items out.
// Depends on beq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface beq_in_if import beq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [STIDX_W-1:0]         stage_index;
  logic [SEL_W-1:0]           coef_select;
  logic signed [COEF_W-1:0]   coef_value;

  modport source (output valid, req_type, sample_in, stage_index, coef_select, coef_value,
                  input ready);
  modport sink (input valid, req_type, sample_in, stage_index, coef_select, coef_value,
                output ready);
endinterface

interface beq_out_if import beq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       is_sample;
  logic                       clipped;

  modport source (output valid, sample_out, is_sample, clipped, input ready);
  modport sink (input valid, sample_out, is_sample, clipped, output ready);
endinterface

`default_nettype wire

// ===== sv/beq_coef_ram.sv =====
// Coefficient store: five words per stage, one write and one registered read a cycle.
// Depends on beq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module beq_coef_ram import beq_pkg::*; #(
  parameter int DEPTH = (NUM_NODES_DEF + 2 * CUT_STAGES_DEF) * NUM_COEFS
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic signed [COEF_W-1:0]   wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic signed [COEF_W-1:0]        rd_data
);

  logic signed [COEF_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/beq_seq.sv =====
// Sequencer: request decode, stage walk over enabled stages, five multiply phases per stage.
// Depends on beq_pkg; drives beq_dp and beq_coef_ram.
`timescale 1ns / 1ps
`default_nettype none

module beq_seq import beq_pkg::*; #(
  parameter int NUM_NODES  = NUM_NODES_DEF,
  parameter int CUT_STAGES = CUT_STAGES_DEF,
  parameter int NUM_STAGES = NUM_NODES + 2 * CUT_STAGES,
  parameter int ADDR_W     = $clog2(NUM_STAGES * NUM_COEFS)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic [REQ_W-1:0]               in_req,
  input  wire logic [STIDX_W-1:0]             in_stage,
  input  wire logic [SEL_W-1:0]               in_sel,
  input  wire logic [MASK_W-1:0]              node_mask,
  input  wire logic                           low_cut,
  input  wire logic                           high_cut,
  input  wire logic                           out_free,
  output logic                                in_ready,
  output beq_ctrl_t                           ctrl,
  output logic [$clog2(NUM_STAGES)-1:0]       stage_idx,
  output logic [$clog2(NUM_STAGES)-1:0]       prev_idx,
  output logic [ADDR_W-1:0]                   rd_addr,
  output logic                                wr_en,
  output logic [ADDR_W-1:0]                   wr_addr,
  output logic                                res_sample,
  output logic                                out_load
);

  localparam int STAGE_W = $clog2(NUM_STAGES);

  beq_state_t         state_r, state_nxt;
  beq_phase_t         phase_r, phase_nxt;
  logic [STAGE_W-1:0] s_r, s_nxt;
  logic [STAGE_W-1:0] prev_r, prev_nxt;
  logic               pend_r, pend_nxt;
  logic               res_r, res_nxt;

  logic [NUM_STAGES-1:0] en;
  logic                  nxt_found;
  logic [STAGE_W-1:0]    nxt_idx;

  function automatic logic [ADDR_W-1:0] caddr(input logic [STAGE_W-1:0] st,
                                              input logic [SEL_W-1:0] sel);
    return ADDR_W'(int'(st) * NUM_COEFS + int'(sel));
  endfunction

  // stage enables: nodes, then low-cut, then high-cut
  for (genvar gi = 0; gi < NUM_STAGES; gi++) begin : g_en
    if (gi < NUM_NODES) begin : g_node
      if (gi < MASK_W) begin : g_bit
        assign en[gi] = node_mask[gi];
      end else begin : g_none
        assign en[gi] = 1'b0;
      end
    end else if (gi < NUM_NODES + CUT_STAGES) begin : g_low
      assign en[gi] = low_cut;
    end else begin : g_high
      assign en[gi] = high_cut;
    end
  end

  // first enabled stage (from zero in PRIME, above the current one otherwise)
  always_comb begin
    nxt_found = 1'b0;
    nxt_idx   = '0;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      if (en[i] && ((state_r == S_PRIME) || (STAGE_W'(i) > s_r))) begin
        nxt_found = 1'b1;
        nxt_idx   = STAGE_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    s_nxt     = s_r;
    prev_nxt  = prev_r;
    pend_nxt  = pend_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = (in_req == REQ_SAMPLE);
          state_nxt = (in_req == REQ_SAMPLE) ? S_PRIME : S_FINISH;
        end
      end
      S_PRIME: begin
        pend_nxt = 1'b0;
        if (nxt_found) begin
          s_nxt     = nxt_idx;
          phase_nxt = PH_B0;
          state_nxt = S_RUN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_RUN: begin
        case (phase_r)
          PH_B0: phase_nxt = PH_B1;
          PH_B1: phase_nxt = PH_A1;
          PH_A1: phase_nxt = PH_B2;
          PH_B2: phase_nxt = PH_A2;
          PH_A2: begin
            prev_nxt = s_r;
            pend_nxt = 1'b1;
            if (nxt_found) begin
              s_nxt     = nxt_idx;
              phase_nxt = PH_B0;
            end else begin
              state_nxt = S_DRAIN;
            end
          end
          default: phase_nxt = PH_B0;
        endcase
      end
      S_DRAIN: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '{op: DP_NONE, default: 1'b0};
    in_ready = 1'b0;
    wr_en    = 1'b0;
    out_load = 1'b0;
    rd_addr  = caddr(s_r, COEF_B0);
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        ctrl.load_x  = in_valid && (in_req == REQ_SAMPLE);
        ctrl.clear_z = in_valid && (in_req == REQ_CLEAR);
        wr_en        = in_valid && (in_req == REQ_COEF) && (int'(in_stage) < NUM_STAGES)
                       && (int'(in_sel) < NUM_COEFS);
      end
      S_PRIME: rd_addr = caddr(nxt_idx, COEF_B0);
      S_RUN: begin
        case (phase_r)
          PH_B0: begin
            ctrl.wr_z2 = pend_r;
            rd_addr    = caddr(s_r, COEF_B1);
          end
          PH_B1: begin
            ctrl.op = DP_Y;
            rd_addr = caddr(s_r, COEF_A1);
          end
          PH_A1: begin
            ctrl.op    = DP_LOAD;
            ctrl.mul_y = 1'b1;
            rd_addr    = caddr(s_r, COEF_B2);
          end
          PH_B2: begin
            ctrl.op = DP_SUB;
            rd_addr = caddr(s_r, COEF_A2);
          end
          PH_A2: begin
            ctrl.op    = DP_Z1;
            ctrl.mul_y = 1'b1;
            ctrl.x_adv = 1'b1;
            rd_addr    = caddr(nxt_idx, COEF_B0);
          end
          default: ctrl.op = DP_NONE;
        endcase
      end
      S_DRAIN:  ctrl.wr_z2 = 1'b1;
      S_FINISH: out_load = out_free;
      default:  in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_B0;
      s_r     <= '0;
      prev_r  <= '0;
      pend_r  <= 1'b0;
      res_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      s_r     <= s_nxt;
      prev_r  <= prev_nxt;
      pend_r  <= pend_nxt;
      res_r   <= res_nxt;
    end
  end

  assign wr_addr    = ADDR_W'(int'(in_stage) * NUM_COEFS + int'(in_sel));
  assign stage_idx  = s_r;
  assign prev_idx   = prev_r;
  assign res_sample = res_r;

endmodule

`default_nettype wire

// ===== sv/beq_dp.sv =====
// Datapath: shared 32x32 multiplier, rounding, accumulator and per-stage delay state.
// Depends on beq_pkg; controlled by beq_seq.
`timescale 1ns / 1ps
`default_nettype none

module beq_dp import beq_pkg::*; #(
  parameter int NUM_STAGES = NUM_NODES_DEF + 2 * CUT_STAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire beq_ctrl_t                     ctrl,
  input  wire logic [$clog2(NUM_STAGES)-1:0] stage_idx,
  input  wire logic [$clog2(NUM_STAGES)-1:0] prev_idx,
  input  wire logic signed [COEF_W-1:0]      coef_q,
  input  wire logic signed [SAMPLE_W-1:0]    sample_in,
  output logic signed [SAMPLE_W-1:0]         sat_sample,
  output logic                               sat_clip
);

  logic signed [Z_W-1:0]    z1_r [NUM_STAGES];
  logic signed [Z_W-1:0]    z2_r [NUM_STAGES];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [Y_W-1:0]    x_r;
  logic signed [Y_W-1:0]    y_r;

  logic signed [Y_W-1:0]    opnd;
  logic signed [PROD_W-1:0] mul_full;
  logic signed [RND_W-1:0]  rnd;
  logic signed [Z_W-1:0]    z1_sel;
  logic signed [Z_W-1:0]    z2_sel;
  logic signed [Z_W-1:0]    acc48;
  logic signed [Z_W-1:0]    z1_new;
  logic signed [Z_W-1:0]    z2_new;
  logic [Y_W-SAMPLE_W:0]    x_hi;

  assign opnd     = ctrl.mul_y ? y_r : x_r;
  assign mul_full = coef_q * opnd;
  assign rnd      = round10(prod_r);
  assign z1_sel   = z1_r[stage_idx];
  assign z2_sel   = z2_r[stage_idx];
  assign acc48    = sat48(SUM_W'(rnd) + SUM_W'(z1_sel));
  assign z1_new   = sat48(SUM_W'(acc_r) + SUM_W'(z2_sel));
  assign z2_new   = sat48(SUM_W'(acc_r) - SUM_W'(rnd));

  always_ff @(posedge clk) begin
    prod_r <= mul_full;
    if (ctrl.op == DP_Y) begin
      y_r <= y_round(acc48);
    end
    case (ctrl.op)
      DP_LOAD: acc_r <= ACC_W'(rnd);
      DP_SUB:  acc_r <= acc_r - ACC_W'(rnd);
      DP_Z1:   acc_r <= ACC_W'(rnd);
      default: acc_r <= acc_r;
    endcase
    if (ctrl.load_x) begin
      x_r <= Y_W'(sample_in);
    end else if (ctrl.x_adv) begin
      x_r <= y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear_z) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        z1_r[i] <= '0;
        z2_r[i] <= '0;
      end
    end else begin
      if (ctrl.op == DP_Z1) begin
        z1_r[stage_idx] <= z1_new;
      end
      if (ctrl.wr_z2) begin
        z2_r[prev_idx] <= z2_new;
      end
    end
  end

  // final saturation to Q0.23
  assign x_hi     = x_r[Y_W-1:SAMPLE_W-1];
  assign sat_clip = !((&x_hi) || (~|x_hi));
  always_comb begin
    if (!sat_clip) begin
      sat_sample = x_r[SAMPLE_W-1:0];
    end else if (x_r[Y_W-1]) begin
      sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== sv/biquad_cascade_equalizer.sv =====
// Top level of the biquad cascade equalizer: config registers, output register, sequencer,
// datapath and coefficient store. Depends on beq_pkg, beq_if, beq_coef_ram, beq_seq, beq_dp.
//
//   channel  direction  handshake          payload
//   in_ch    in         valid/ready        req_type, sample_in, stage_index, coef_select,
//                                          coef_value
//   out_ch   out        valid/ready        sample_out, is_sample, clipped
//   cfg_*    in         cfg_we (no stall)  cfg_index, cfg_wdata
//
// A sample item with n > 0 enabled stages passes prime, five products per stage on one 32x32
// multiplier, a z2 drain and the load of the result register; the next transfer is taken
// once the sequencer is back in idle. With no stage enabled a sample goes from prime
// straight to the load; writes, clears and other requests go from idle to the load.
// in_ch.ready is high only while idle; a result stalled in the output register holds
// the sequencer in its last step. Synchronous active-low reset clears config and delay state.
`timescale 1ns / 1ps
`default_nettype none

module biquad_cascade_equalizer import beq_pkg::*; #(
  parameter int NUM_NODES  = NUM_NODES_DEF,
  parameter int CUT_STAGES = CUT_STAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  beq_in_if.sink                    in_ch,
  beq_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MASK_W-1:0]    cfg_wdata
);

  localparam int NUM_STAGES = NUM_NODES + 2 * CUT_STAGES;
  localparam int RAM_DEPTH  = NUM_STAGES * NUM_COEFS;
  localparam int ADDR_W     = $clog2(RAM_DEPTH);
  localparam int STAGE_W    = $clog2(NUM_STAGES);

  logic [MASK_W-1:0] node_mask_r;
  logic              low_cut_r;
  logic              high_cut_r;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_is_sample_r;
  logic                       out_clipped_r;

  beq_ctrl_t                ctrl;
  logic [STAGE_W-1:0]       stage_idx;
  logic [STAGE_W-1:0]       prev_idx;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     wr_en;
  logic signed [COEF_W-1:0] coef_q;
  logic                     res_sample;
  logic                     out_load;
  logic                     out_free;
  logic signed [SAMPLE_W-1:0] sat_sample;
  logic                     sat_clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_mask_r <= '0;
      low_cut_r   <= 1'b0;
      high_cut_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_MASK: node_mask_r <= cfg_wdata;
        CFG_LOW_CUT:   low_cut_r   <= cfg_wdata[0];
        CFG_HIGH_CUT:  high_cut_r  <= cfg_wdata[0];
        default:       node_mask_r <= node_mask_r;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  beq_seq #(
    .NUM_NODES  (NUM_NODES),
    .CUT_STAGES (CUT_STAGES),
    .NUM_STAGES (NUM_STAGES),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_req     (in_ch.req_type),
    .in_stage   (in_ch.stage_index),
    .in_sel     (in_ch.coef_select),
    .node_mask  (node_mask_r),
    .low_cut    (low_cut_r),
    .high_cut   (high_cut_r),
    .out_free   (out_free),
    .in_ready   (in_ch.ready),
    .ctrl       (ctrl),
    .stage_idx  (stage_idx),
    .prev_idx   (prev_idx),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .res_sample (res_sample),
    .out_load   (out_load)
  );

  beq_coef_ram #(
    .DEPTH (RAM_DEPTH)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.coef_value),
    .rd_addr (rd_addr),
    .rd_data (coef_q)
  );

  beq_dp #(
    .NUM_STAGES (NUM_STAGES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stage_idx  (stage_idx),
    .prev_idx   (prev_idx),
    .coef_q     (coef_q),
    .sample_in  (in_ch.sample_in),
    .sat_sample (sat_sample),
    .sat_clip   (sat_clip)
  );

  // result register
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r    <= res_sample ? sat_sample : '0;
      out_is_sample_r <= res_sample;
      out_clipped_r   <= res_sample && sat_clip;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.is_sample  = out_is_sample_r;
  assign out_ch.clipped    = out_clipped_r;

  // busy right after any transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready while an item is in flight");

  a_clip_only_samples: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.clipped) |-> out_ch.is_sample)
    else $error("clip flag on a non-sample result");

  a_zero_non_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.is_sample) |-> (out_ch.sample_out == '0))
    else $error("non-sample result carries sample data");

  // deferred z2 write never coincides with an accumulator step
  a_z2_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_z2 |-> (ctrl.op == DP_NONE))
    else $error("z2 write overlaps a datapath step");

endmodule

`default_nettype wire
